// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define WSDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true outside reset
`define WSDQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/wsdq_pkg.sv =====
// ----------------------------------------------------------------------------
// wsdq_pkg
// shared types and constants of the subband dead-zone quantizer
// ----------------------------------------------------------------------------
package wsdq_pkg;

  localparam int COEF_W = 32;
  localparam int POS_W  = 12;
  localparam int DIM_W  = 13;
  localparam int EXP_W  = 5;
  localparam int MANT_W = 11;
  localparam int ROFS_W = 8;
  localparam int LVL_W  = 4;
  localparam int E_W    = 8;

  // configuration register map, word index
  typedef enum logic [2:0] {
    REG_DIRECTION = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_WIDTH     = 3'd2,
    REG_RANGE     = 3'd3,
    REG_EXPONENT  = 3'd4,
    REG_MANTISSA  = 3'd5,
    REG_ROFFSET   = 3'd6,
    REG_NONE      = 3'd7
  } reg_idx_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              covered;
    logic [E_W-1:0]    e;        // two's complement step exponent
    logic [COEF_W-1:0] coef;
  } item_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/wsdq_front.sv =====
// ----------------------------------------------------------------------------
// wsdq_front
// accepts coefficients, finds subband level and gain, forms the step exponent
// ----------------------------------------------------------------------------
module wsdq_front #(
  parameter int TRANSFORM_DEPTH = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wsdq_pkg::POS_W-1:0]   in_row,
  input  logic [wsdq_pkg::POS_W-1:0]   in_col,
  input  logic [wsdq_pkg::COEF_W-1:0]  in_coefficient,
  input  logic [wsdq_pkg::DIM_W-1:0]   image_height,
  input  logic [wsdq_pkg::DIM_W-1:0]   image_width,
  input  logic [wsdq_pkg::EXP_W-1:0]   dynamic_range,
  input  logic [wsdq_pkg::EXP_W-1:0]   base_exponent,
  input  wsdq_pkg::q_stat_t            q_stat,
  output logic                         push,
  output wsdq_pkg::item_t              push_item
);

  logic                         fv_r;
  wsdq_pkg::item_t              item_r;
  wsdq_pkg::item_t              item_nxt;
  logic [13:0]                  sh, sw, dh, dw, row_x, col_x;
  logic                         covered;
  logic [wsdq_pkg::LVL_W-1:0]   level;
  logic [1:0]                   gain;

  assign in_ready  = !fv_r || !q_stat.full;
  assign push      = fv_r && !q_stat.full;
  assign push_item = item_r;

  always_comb begin
    sh      = 14'({1'b0, image_height} >> TRANSFORM_DEPTH);
    sw      = 14'({1'b0, image_width} >> TRANSFORM_DEPTH);
    row_x   = {2'b0, in_row};
    col_x   = {2'b0, in_col};
    covered = 1'b0;
    level   = '0;
    gain    = 2'd0;
    dh      = '0;
    dw      = '0;
    // lowest detail level wins, so walk from the top down
    for (int i = TRANSFORM_DEPTH - 1; i >= 0; i--) begin
      dh = sh << i;
      dw = sw << i;
      if (row_x < (dh << 1) && col_x < (dw << 1) && (row_x >= dh || col_x >= dw)) begin
        covered = 1'b1;
        level   = wsdq_pkg::LVL_W'(i);
        gain    = (row_x >= dh && col_x >= dw) ? 2'd2 : 2'd1;
      end
    end
    if (row_x < sh && col_x < sw) begin
      covered = 1'b1;
      level   = '0;
      gain    = 2'd0;
    end
    item_nxt.covered = covered;
    item_nxt.e       = {3'b0, dynamic_range} + {6'b0, gain} - {3'b0, base_exponent}
                     - {4'b0, level} + wsdq_pkg::E_W'(TRANSFORM_DEPTH);
    item_nxt.coef    = in_coefficient;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/wsdq_queue.sv =====
// ----------------------------------------------------------------------------
// wsdq_queue
// two-entry queue between the classifier and the arithmetic pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsdq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wsdq_pkg::item_t  push_item,
  input  logic             pop,
  output wsdq_pkg::item_t  pop_item,
  output wsdq_pkg::q_stat_t q_stat
);

  wsdq_pkg::item_t mem_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign pop_item     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  `WSDQ_NEVER(a_no_overflow, push && cnt_r == 2'd2, "queue push while full")
  `WSDQ_NEVER(a_no_underflow, pop && cnt_r == 2'd0, "queue pop while empty")

endmodule

// ===== rtl/wsdq_back.sv =====
// ----------------------------------------------------------------------------
// wsdq_back
// step arithmetic: pipelined divider for quantize, multiplier for reconstruct
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsdq_back #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wsdq_pkg::q_stat_t             q_stat,
  input  wsdq_pkg::item_t               pop_item,
  output logic                          pop,
  input  logic                          direction,
  input  logic [wsdq_pkg::MANT_W-1:0]   step_mantissa,
  input  logic [wsdq_pkg::ROFS_W-1:0]   recon_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wsdq_pkg::COEF_W-1:0]   out_result,
  output logic                          out_saturated
);

  localparam int QB     = 33;          // quotient bits kept
  localparam int BPS    = 3;           // quotient bits per stage
  localparam int STAGES = QB / BPS + 1;
  localparam int SMAX   = 44;
  localparam int NW     = 32 + SMAX;
  localparam int MW     = QB + 16;

  typedef struct packed {
    logic              fwd;
    logic              inv;
    logic              neg;
    logic [31:0]       pass;
    logic [11:0]       rem;
    logic [QB-1:0]     num;
    logic [QB-1:0]     quo;
    logic              ovf;
    logic [52:0]       p;
    logic signed [8:0] t;
  } bk_t;

  bk_t               st_r [STAGES];
  bk_t               st_nxt [STAGES];
  bk_t               entry_nxt;
  logic [STAGES-1:0] vld_r;
  logic              adv;
  logic              out_valid_r, out_saturated_r, out_saturated_nxt;
  logic [31:0]       out_result_r, out_result_nxt;
  logic [11:0]       m;

  assign m   = {1'b1, step_mantissa};
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_stat.empty;

  function automatic bk_t div_steps(input bk_t x, input logic [11:0] d);
    bk_t         y;
    logic [12:0] r2;
    y = x;
    for (int j = 0; j < BPS; j++) begin
      r2    = {y.rem, y.num[QB-1]};
      y.num = {y.num[QB-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        y.rem = 12'(r2 - {1'b0, d});
        y.quo = {y.quo[QB-2:0], 1'b1};
      end else begin
        y.rem = r2[11:0];
        y.quo = {y.quo[QB-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  function automatic bk_t inv_shift(input bk_t x);
    bk_t         y;
    logic [83:0] sh;
    logic [8:0]  k;
    y  = x;
    sh = '0;
    k  = 9'(-x.t);
    if (x.t < 0) begin
      sh = (k >= 9'd53) ? '0 : ({31'b0, x.p} >> k[5:0]);
      y.ovf = |sh[83:QB];
    end else if (x.t > 9'sd31) begin
      y.ovf = |x.p;
    end else begin
      sh = {31'b0, x.p} << x.t[4:0];
      y.ovf = |sh[83:QB];
    end
    y.quo = sh[QB-1:0];
    return y;
  endfunction

  // entry stage: magnitude, dividend alignment, product
  always_comb begin
    logic [31:0]       v, a;
    logic signed [8:0] s, e9;
    logic [8:0]        k;
    logic [NW-1:0]     n_al;
    logic              big;
    logic [42:0]       hi;
    logic [40:0]       n;
    v    = pop_item.coef;
    a    = v[31] ? (~v + 32'd1) : v;
    e9   = $signed({pop_item.e[7], pop_item.e});
    s    = 9'sd11 - $signed(9'(FRACTION_BITS)) - e9;
    k    = 9'(-s);
    big  = 1'b0;
    n_al = '0;
    if (s < 0) begin
      n_al = (k >= 9'd32) ? '0 : NW'(a >> k[4:0]);
    end else if (s > 9'sd44) begin
      big = |a;
    end else begin
      n_al = {{SMAX{1'b0}}, a} << s[5:0];
    end
    hi = n_al[NW-1:QB];
    n  = {1'b0, a, 8'b0} + (41'({33'b0, recon_offset}) << FRACTION_BITS);
    entry_nxt.fwd  = pop_item.covered && !direction;
    entry_nxt.inv  = pop_item.covered && direction;
    entry_nxt.neg  = v[31];
    entry_nxt.pass = v;
    entry_nxt.rem  = hi[11:0];
    entry_nxt.num  = n_al[QB-1:0];
    entry_nxt.quo  = '0;
    entry_nxt.ovf  = big || (|hi[42:12]) || (hi[11:0] >= m);
    entry_nxt.p    = {12'b0, n} * {41'b0, m};
    entry_nxt.t    = e9 - 9'sd19;
  end

  always_comb begin
    st_nxt[0] = entry_nxt;
    for (int i = 1; i < STAGES; i++) begin
      if (st_r[i-1].fwd) st_nxt[i] = div_steps(st_r[i-1], m);
      else if (st_r[i-1].inv && i == 1) st_nxt[i] = inv_shift(st_r[i-1]);
      else st_nxt[i] = st_r[i-1];
    end
  end

  // saturation and sign
  always_comb begin
    bk_t         x;
    logic [MW-1:0] magw, lim;
    logic        sat;
    x    = st_r[STAGES-1];
    magw = x.fwd ? (MW'(x.quo) << FRACTION_BITS) : MW'(x.quo);
    lim  = x.neg ? MW'(32'h8000_0000) : MW'(32'h7FFF_FFFF);
    sat  = x.ovf || (magw > lim);
    if (!x.fwd && !x.inv) begin
      out_result_nxt    = x.pass;
      out_saturated_nxt = 1'b0;
    end else if (sat) begin
      out_result_nxt    = x.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      out_saturated_nxt = 1'b1;
    end else begin
      out_result_nxt    = x.neg ? (~magw[31:0] + 32'd1) : magw[31:0];
      out_saturated_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[STAGES-2:0], pop};
      out_valid_r <= vld_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < STAGES; i++) st_r[i] <= st_nxt[i];
      out_result_r    <= out_result_nxt;
      out_saturated_r <= out_saturated_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_saturated = out_saturated_r;

  `WSDQ_ASSERT(a_sat_limit, out_valid_r && out_saturated_r |->
    out_result_r == 32'h8000_0000 || out_result_r == 32'h7FFF_FFFF,
    "saturated result is not a range limit")

endmodule

// ===== rtl/wavelet_subband_deadzone_quantizer.sv =====
// ----------------------------------------------------------------------------
// wavelet_subband_deadzone_quantizer
// subband-aware dead-zone quantizer and reconstructor for wavelet coefficients
// ----------------------------------------------------------------------------
// path from input transfer to out_valid: front register, queue slot, entry stage,
//   11 divide stages and the output register
// throughput: one transfer per cycle in both directions while out_ready is high,
//   set by the 3-bit-per-stage divider pipeline, taking a new dividend every cycle
// reset: rst_n is synchronous, active low; clears handshake state and loads the
//   register defaults (forward, 512 x 512, range 8, exponent 8, mantissa 0, offset 128)
module wavelet_subband_deadzone_quantizer #(
  parameter int TRANSFORM_DEPTH = 3,
  parameter int FRACTION_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // coefficient input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_row,
  input  logic [11:0] in_col,
  input  logic [31:0] in_coefficient,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result,
  output logic        out_saturated,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic                               direction_r;
  logic [wsdq_pkg::DIM_W-1:0]         height_r, width_r;
  logic [wsdq_pkg::EXP_W-1:0]         range_r, exponent_r;
  logic [wsdq_pkg::MANT_W-1:0]        mantissa_r;
  logic [wsdq_pkg::ROFS_W-1:0]        roffset_r;
  wsdq_pkg::reg_idx_t                 reg_idx;
  logic                               wr_en;

  // front to queue to back
  wsdq_pkg::q_stat_t                  q_stat;
  wsdq_pkg::item_t                    push_item, pop_item;
  logic                               push, pop;

  assign pready  = 1'b1;
  assign reg_idx = wsdq_pkg::reg_idx_t'(paddr[4:2]);
  // write lands in the access phase
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      height_r    <= 13'd512;
      width_r     <= 13'd512;
      range_r     <= 5'd8;
      exponent_r  <= 5'd8;
      mantissa_r  <= '0;
      roffset_r   <= 8'd128;
    end else if (wr_en) begin
      case (reg_idx)
        wsdq_pkg::REG_DIRECTION: direction_r <= pwdata[0];
        wsdq_pkg::REG_HEIGHT:    height_r    <= pwdata[12:0];
        wsdq_pkg::REG_WIDTH:     width_r     <= pwdata[12:0];
        wsdq_pkg::REG_RANGE:     range_r     <= pwdata[4:0];
        wsdq_pkg::REG_EXPONENT:  exponent_r  <= pwdata[4:0];
        wsdq_pkg::REG_MANTISSA:  mantissa_r  <= pwdata[10:0];
        wsdq_pkg::REG_ROFFSET:   roffset_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux, zero extended
  always_comb begin
    case (reg_idx)
      wsdq_pkg::REG_DIRECTION: prdata = {31'b0, direction_r};
      wsdq_pkg::REG_HEIGHT:    prdata = {19'b0, height_r};
      wsdq_pkg::REG_WIDTH:     prdata = {19'b0, width_r};
      wsdq_pkg::REG_RANGE:     prdata = {27'b0, range_r};
      wsdq_pkg::REG_EXPONENT:  prdata = {27'b0, exponent_r};
      wsdq_pkg::REG_MANTISSA:  prdata = {21'b0, mantissa_r};
      wsdq_pkg::REG_ROFFSET:   prdata = {24'b0, roffset_r};
      default:                 prdata = '0;
    endcase
  end

  // classification: subband level, gain and step exponent
  wsdq_front #(
    .TRANSFORM_DEPTH (TRANSFORM_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_coefficient (in_coefficient),
    .image_height   (height_r),
    .image_width    (width_r),
    .dynamic_range  (range_r),
    .base_exponent  (exponent_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  // decoupling queue so either side can stall alone
  wsdq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // arithmetic pipeline with the output register
  wsdq_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_item      (pop_item),
    .pop           (pop),
    .direction     (direction_r),
    .step_mantissa (mantissa_r),
    .recon_offset  (roffset_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result    (out_result),
    .out_saturated (out_saturated)
  );

endmodule

// ===== bench/tb_wavelet_subband_deadzone_quantizer.sv =====
// ----------------------------------------------------------------------------
// tb_wavelet_subband_deadzone_quantizer
// self-checking bench for the subband dead-zone quantizer: a scoreboard class
// predicts each result from its own copy of the registers, and random
// coefficients run through several register settings with idle bursts
// ----------------------------------------------------------------------------
module tb_wavelet_subband_deadzone_quantizer;

  localparam int DEPTH      = 3;    // transform depth of the dut
  localparam int FRAC       = 8;    // fraction bits of the dut
  localparam int MANT_BITS  = 11;   // step mantissa width
  localparam int DRAIN_WAIT = 30;   // margin over the pipeline latency
  localparam int CYCLE_CAP  = 600000;

  // one expected result
  typedef struct {
    logic [31:0] result;
    logic        saturated;
  } quant_result_t;

  // predicts each quantized or reconstructed value and checks the dut output
  class deadzone_scoreboard;
    bit          inverse;
    bit   [12:0] height, width;
    bit   [4:0]  drange, bexp;
    bit   [10:0] mant;
    bit   [7:0]  roffset;
    quant_result_t pending[$];
    int          errors;

    function void reset_regs();
      inverse = 0; height = 512; width = 512; drange = 8; bexp = 8;
      mant = 0; roffset = 128;
    endfunction

    function void write_reg(wsdq_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        wsdq_pkg::REG_DIRECTION: inverse = val[0];
        wsdq_pkg::REG_HEIGHT:    height  = val[12:0];
        wsdq_pkg::REG_WIDTH:     width   = val[12:0];
        wsdq_pkg::REG_RANGE:     drange  = val[4:0];
        wsdq_pkg::REG_EXPONENT:  bexp    = val[4:0];
        wsdq_pkg::REG_MANTISSA:  mant    = val[10:0];
        wsdq_pkg::REG_ROFFSET:   roffset = val[7:0];
        default: ;
      endcase
    endfunction

    // subband lookup, returns 0 for a position outside every band
    function bit find_band(bit [11:0] row, bit [11:0] col, output int level,
                           output int gain);
      longint unsigned sh, sw, dh, dw;
      sh = height >> DEPTH;
      sw = width >> DEPTH;
      level = 0;
      gain = 0;
      if (row < sh && col < sw) return 1;
      for (int i = 0; i < DEPTH; i++) begin
        dh = sh << i;
        dw = sw << i;
        if (row < (dh << 1) && col < (dw << 1)) begin
          level = i;
          if (row >= dh && col >= dw) begin
            gain = 2;
            return 1;
          end
          if (row >= dh || col >= dw) begin
            gain = 1;
            return 1;
          end
        end
      end
      return 0;
    endfunction

    function logic [31:0] clip(bit neg, longint unsigned mag, bit big, output bit sat);
      longint unsigned lim;
      lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      sat = big || mag > lim;
      if (sat) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
      return neg ? 32'(0 - mag) : 32'(mag);
    endfunction

    function void note_coefficient(bit [11:0] row, bit [11:0] col, logic [31:0] coef);
      quant_result_t   exp_r;
      bit              neg, big, sat;
      longint unsigned a, m, q, r, n, p, mag;
      int              level, gain, e, s, t;
      neg = coef[31];
      a = neg ? longint'(32'(0 - coef)) : longint'(coef);
      if (coef == 32'h8000_0000) a = 64'h8000_0000;
      m = 2048 + mant;
      big = 0;
      if (!find_band(row, col, level, gain)) begin
        exp_r.result = coef;
        exp_r.saturated = 0;
        pending.push_back(exp_r);
        return;
      end
      e = int'(drange) + gain - int'(bexp) - level + DEPTH;
      if (!inverse) begin
        s = MANT_BITS - FRAC - e;
        if (s < 0) begin
          q = (-s >= 64) ? 0 : (a >> -s) / m;
        end else begin
          r = a % m;
          q = a / m;
          for (int i = 0; i < s; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= m) begin
              r = r - m;
              q = q | 1;
            end
            if (q >= (64'd1 << 40)) begin
              big = 1;
              break;
            end
          end
        end
        if (!big) q = q << FRAC;
        exp_r.result = clip(neg, q, big, sat);
      end else begin
        n = (a << 8) + (longint'(roffset) << FRAC);
        p = n * m;
        t = e - 19;
        mag = 0;
        if (t >= 0) begin
          if (p != 0) begin
            if (t >= 32 || p > ((64'd1 << 31) >> t)) big = 1;
            else mag = p << t;
          end
        end else begin
          mag = (-t >= 64) ? 0 : p >> -t;
        end
        exp_r.result = clip(neg, mag, big, sat);
      end
      exp_r.saturated = sat;
      pending.push_back(exp_r);
    endfunction

    function void check_result(logic [31:0] result, logic saturated);
      quant_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h sat %b", $time, result, saturated);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (result !== exp_r.result) begin
        $display("%0t: result expected %h actual %h", $time, exp_r.result, result);
        errors++;
      end
      if (saturated !== exp_r.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, exp_r.saturated,
                 saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [11:0] in_row, in_col;
  logic [31:0] in_coefficient;
  logic        out_valid, out_ready;
  logic [31:0] out_result;
  logic        out_saturated;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  deadzone_scoreboard sb;
  bit idle_on;       // random idle bursts on both sides
  bit hold_request;  // asks the receiver for one long hold-off
  int cycle_count;

  wavelet_subband_deadzone_quantizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_row(in_row), .in_col(in_col),
    .in_coefficient(in_coefficient),
    .out_valid(out_valid), .out_ready(out_ready), .out_result(out_result),
    .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock, period 2
  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // run limit, well above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: outputs are read at the falling edge, where they are settled;
  // a transfer at the next rising edge is certain once valid and ready are high
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_result, out_saturated);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_ready <= 0;
        repeat (300) @(posedge clk);
        out_ready <= 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // register write: setup phase, access phase, then idle; called right after a rising edge
  task automatic write_reg(wsdq_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // offer one coefficient and wait for its transfer
  task automatic send_coef(logic [11:0] row, logic [11:0] col, logic [31:0] coef);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid       <= 1;
    in_row         <= row;
    in_col         <= col;
    in_coefficient <= coef;
    do @(negedge clk); while (!in_ready);
    sb.note_coefficient(row, col, coef);
    @(posedge clk);
  endtask

  // wait until every expected result has come, plus the DRAIN_WAIT margin
  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef(bit inv);
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom >> $urandom_range(0, 31);
      2:       return -($urandom >> $urandom_range(0, 31));
      3:       return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return inv ? 32'($signed($urandom_range(0, 64)) - 32) :
                            32'($signed($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  // positions mostly inside the covered area, sometimes anywhere
  function automatic logic [11:0] rand_pos(bit [12:0] dim);
    int hi;
    hi = (dim > 4096) ? 4095 : int'(dim) - 1;
    if (hi < 0 || $urandom_range(0, 4) == 0) return 12'($urandom);
    return 12'($urandom_range(0, hi));
  endfunction

  // register value with random junk above the register width
  function automatic logic [31:0] with_junk(logic [31:0] val, int w);
    return val | (($urandom_range(0, 1) ? $urandom : 32'd0) << w);
  endfunction

  task automatic set_phase(bit inv, int h, int w, int rng, int ex, int mt, int ro);
    write_reg(wsdq_pkg::REG_DIRECTION, with_junk(inv, 1));
    write_reg(wsdq_pkg::REG_HEIGHT, with_junk(h, 13));
    write_reg(wsdq_pkg::REG_WIDTH, with_junk(w, 13));
    write_reg(wsdq_pkg::REG_RANGE, with_junk(rng, 5));
    write_reg(wsdq_pkg::REG_EXPONENT, with_junk(ex, 5));
    write_reg(wsdq_pkg::REG_MANTISSA, with_junk(mt, 11));
    write_reg(wsdq_pkg::REG_ROFFSET, with_junk(ro, 8));
  endtask

  initial begin
    logic [31:0] edge_vals[5];
    sb = new();
    sb.reset_regs();
    idle_on = 0;
    hold_request = 0;
    rst_n = 0;
    in_valid = 0;
    in_row = 0;
    in_col = 0;
    in_coefficient = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults, one item per band kind and value extreme
    edge_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    send_coef(0, 0, 32'h0000_1234);         // low-pass band
    send_coef(0, 64, 32'hffff_8000);        // coarsest detail, gain 1
    send_coef(64, 0, 32'h0010_0000);
    send_coef(64, 64, 32'h7fff_ffff);       // coarsest diagonal, gain 2
    send_coef(511, 511, 32'h8000_0000);     // finest diagonal
    send_coef(512, 0, 32'h5555_aaaa);       // outside every band
    send_coef(4095, 4095, 32'h8000_0000);
    foreach (edge_vals[i]) send_coef(200, 10, edge_vals[i]);
    drain();
    // inverse: zero index counts as positive, huge indices saturate
    write_reg(wsdq_pkg::REG_DIRECTION, 1);
    foreach (edge_vals[i]) send_coef(100, 300, edge_vals[i]);
    send_coef(0, 0, 32'hffff_fffd);
    send_coef(4000, 17, 32'h0000_0abc);
    drain();
    write_reg(wsdq_pkg::REG_NONE, 32'hffff_ffff);     // unmapped register, no effect

    // random phases, extremes first
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:  set_phase(0, 512, 512, 8, 8, 0, 128);
        1:  set_phase(1, 512, 512, 8, 8, 0, 128);
        2:  set_phase(0, 4096, 4096, 31, 0, 2047, 255);
        3:  set_phase(0, 64, 96, 0, 31, 0, 0);
        4:  set_phase(1, 4096, 4096, 31, 0, 2047, 255);
        5:  set_phase(1, 40, 24, 0, 31, 2047, 0);
        6:  set_phase(0, 1, 4096, 10, 3, 1000, 7);    // nothing covered
        7:  set_phase(1, 4096, 8, 12, 20, 5, 200);
        default:
          set_phase($urandom_range(0, 1), $urandom_range(1, 4096), $urandom_range(1, 4096),
                    $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 2047), $urandom_range(0, 255));
      endcase
      idle_on = (ph < 10);
      if (ph == 1) hold_request = 1;  // block fills up while the receiver holds off
      for (int k = 0; k < 70; k++) begin
        if (ph == 3 && k == 35) drain();  // sender pause until all results are in
        send_coef(rand_pos(sb.height), rand_pos(sb.width), rand_coef(sb.inverse));
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
